@@ rtl/core/bsd_pkg.sv @@
`default_nettype none

package bsd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 16;

    localparam logic [ByteW-1:0]  HdrByte    = 8'hff;
    localparam logic [ByteW-1:0]  EscByte    = 8'hfd;
    localparam logic [ByteW-1:0]  EscFf      = 8'hfe;
    localparam logic [CountW-1:0] MaxOutInit = 16'hffff;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LENH = 2'd1,
        PH_LENL = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    typedef struct packed {
        logic [ByteW-1:0]  out_byte;
        logic              has_data;
        logic              frame_end;
        logic [CountW-1:0] out_count;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/bsd_core.sv @@
`default_nettype none

module bsd_core
    import bsd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CountW-1:0] i_cfg_wdata,
    input  wire logic              i_accept,
    input  wire logic [ByteW-1:0]  i_rx_byte,
    output      logic              o_res_valid,
    output      t_result           o_res
);

    t_phase            r_phase, n_phase;
    logic              r_esc, n_esc;
    logic [ByteW-1:0]  r_len_high, n_len_high;
    logic [CountW-1:0] r_left, n_left;
    logic [CountW-1:0] r_delivered, n_delivered;
    logic [CountW-1:0] r_max_out;

    logic [CountW-1:0] len;
    logic              len_empty;
    logic              dec_have;
    logic [ByteW-1:0]  dec_byte;
    logic              keep;
    logic [CountW-1:0] left_dec;
    logic              last;

    assign len       = {r_len_high, i_rx_byte};
    assign len_empty = (len == '0) || len[CountW-1];
    assign left_dec  = r_left - CountW'(1);
    assign last      = (left_dec == '0);
    assign keep      = dec_have && (r_delivered < r_max_out);

    // unstuff one payload byte
    always_comb begin
        dec_have = 1'b0;
        dec_byte = '0;
        if (r_esc) begin
            if (i_rx_byte == EscFf) begin
                dec_have = 1'b1;
                dec_byte = HdrByte;
            end else if (i_rx_byte == EscByte) begin
                dec_have = 1'b1;
                dec_byte = EscByte;
            end
        end else if (i_rx_byte != EscByte) begin
            dec_have = 1'b1;
            dec_byte = i_rx_byte;
        end
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT: if (i_rx_byte == HdrByte) n_phase = PH_LENH;
            PH_LENH: n_phase = PH_LENL;
            PH_LENL: n_phase = len_empty ? PH_HUNT : PH_DATA;
            PH_DATA: if (last) n_phase = PH_HUNT;
            default: n_phase = PH_HUNT;
        endcase
    end

    always_comb begin
        n_esc       = r_esc;
        n_len_high  = r_len_high;
        n_left      = r_left;
        n_delivered = r_delivered;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (r_phase)
            PH_HUNT: ;
            PH_LENH: n_len_high = i_rx_byte;
            PH_LENL: begin
                n_esc       = 1'b0;
                n_delivered = '0;
                n_left      = len_empty ? '0 : len;
                if (len_empty) begin
                    o_res_valid     = 1'b1;
                    o_res.frame_end = 1'b1;
                end
            end
            PH_DATA: begin
                n_esc       = r_esc ? 1'b0 : (i_rx_byte == EscByte);
                n_delivered = r_delivered + CountW'(keep);
                n_left      = left_dec;
                o_res_valid = keep || last;
                o_res.out_byte  = keep ? dec_byte : '0;
                o_res.has_data  = keep;
                o_res.frame_end = last;
                o_res.out_count = n_delivered;
                if (last) begin
                    n_esc       = 1'b0;
                    n_delivered = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_esc       <= 1'b0;
            r_len_high  <= '0;
            r_left      <= '0;
            r_delivered <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_esc       <= n_esc;
            r_len_high  <= n_len_high;
            r_left      <= n_left;
            r_delivered <= n_delivered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_out <= MaxOutInit;
        end else if (i_cfg_we) begin
            r_max_out <= i_cfg_wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/byte_stuffing_deframer.sv @@
// Byte-stuffing deframer: takes one received link byte per cycle unless the
// input is stalled, hunts for the 0xff header, reads a 16-bit big-endian
// stuffed length, and unstuffs the payload (fd fe -> ff, fd fd -> fd, other
// escape pairs and a trailing fd are dropped). A result carries one decoded
// byte and/or a frame-end mark with the running count of bytes delivered in
// the frame; a zero or negative length yields a single empty frame-end
// result. Decoded bytes beyond max_out are discarded while the frame is still
// consumed. Each result is registered when its item is taken; a two-entry
// output buffer lets input continue after the output stalls until one more
// result is parked, and input stalls only while that spare entry is full.
`default_nettype none

module byte_stuffing_deframer
    import bsd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CountW-1:0] i_cfg_wdata,
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire logic [ByteW-1:0]  i_rx_byte,
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      logic [ByteW-1:0]  o_out_byte,
    output      logic              o_has_data,
    output      logic              o_frame_end,
    output      logic [CountW-1:0] o_out_count
);

    logic    accept;
    logic    res_valid;
    t_result res;
    logic    out_take;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    bsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= accept && res_valid;
        end else if (accept && res_valid) begin
            // output held: park the new item
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) r_out <= r_skid;
        end else if (!r_out_valid || out_take) begin
            r_out <= res;
        end else begin
            r_skid <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out.out_byte;
    assign o_has_data  = r_out.has_data;
    assign o_frame_end = r_out.frame_end;
    assign o_out_count = r_out.out_count;

endmodule

`default_nettype wire

@@ rtl/core/bsd_checker.sv @@
`default_nettype none

module bsd_checker
    import bsd_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [ByteW-1:0]  o_out_byte,
    input wire logic              o_has_data,
    input wire logic              o_frame_end,
    input wire logic [CountW-1:0] o_out_count
);

    // an item always carries data or closes a frame
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_has_data || o_frame_end))
        else $error("empty result item");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_data) |-> (o_out_byte == '0))
        else $error("byte set without data");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_has_data) |-> (o_out_count != '0))
        else $error("data item with zero count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_out_count)))
        else $error("stalled item changed");

    // input stalls only behind a waiting result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |-> o_out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind byte_stuffing_deframer bsd_checker u_bsd_checker (.*);

`default_nettype wire
